FILE: rtl/grp_pkg.sv
// Package for the gyro rotation PID block: field widths, fixed-point constants,
// register indexes and reset values. No dependencies; every other rtl file imports it.
`default_nettype none

package grp_pkg;

   // fixed-point position of angles and rates
   localparam int FRAC_BITS = 16;

   // transaction field widths
   localparam int REQ_TYPE_W = 1;
   localparam int START_W    = 32;
   localparam int GYRO_W     = 16;
   localparam int US_W       = 20;
   localparam int DRIVE_W    = 9;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int GAIN_W     = 16;
   localparam int TOL_W      = 24;
   localparam int LIM_W      = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_DERIV_GAIN = 3'd2,
      CSR_ERROR_TOL  = 3'd3,
      CSR_RATE_TOL   = 3'd4,
      CSR_MIN_DRIVE  = 3'd5,
      CSR_MAX_DRIVE  = 3'd6
   } csr_index_type;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd512;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd768;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd26;
   localparam logic [TOL_W-1:0]  ERROR_TOL_RST  = 24'd327680;
   localparam logic [TOL_W-1:0]  RATE_TOL_RST   = 24'd655;
   localparam logic [LIM_W-1:0]  MIN_DRIVE_RST  = 8'd75;
   localparam logic [LIM_W-1:0]  MAX_DRIVE_RST  = 8'd255;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_START  = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_SAMPLE = 1'b1;

   // controller state widths
   localparam int STATE_W = 48;

   // gyro scaling: rate = |raw| * 500 * 2^FRAC_BITS / 2^15
   localparam int RAW_MAG_W    = GYRO_W + 1;
   localparam int RAW_PROD_W   = 26;
   localparam int GYRO_SHIFT   = 15;
   localparam int RATE_SCALE_W = RAW_PROD_W + FRAC_BITS;
   localparam int RATE_W       = 31;
   localparam logic [RAW_PROD_W-1:0] GYRO_FULL_SCALE = 26'd500;
   localparam logic [RATE_W-1:0]     RATE_MAX        = {RATE_W{1'b1}};

   localparam logic [US_W-1:0] US_PER_S = 20'd1000000;

   // shared multiplier: operand A in two halves times operand B
   localparam int MUL_A_W    = 49;
   localparam int MUL_HALF_W = 25;
   localparam int MUL_B_W    = 20;
   localparam int MUL_P_W    = MUL_HALF_W + MUL_B_W;
   localparam int PROD_W     = 69;

   // shared divider: 20-bit divisor, quotient developed 4 bits a cycle
   localparam int DIV_R_W       = 20;
   localparam int DIV_Q_W       = 48;
   localparam int DIV_STEP      = 4;
   localparam int DIV_CNT_W     = 4;
   localparam int DIV_K_DELTA   = 32;
   localparam int DIV_K_SUM     = 48;
   localparam int DIV_K_DERIV   = 44;
   localparam int DIV_TOP_W     = PROD_W - DIV_K_DERIV;

   // PID terms
   localparam int TERM_W      = 41;
   localparam logic [TERM_W-1:0] TERM_LIM = {1'b1, {(TERM_W-1){1'b0}}};
   localparam int GAIN_SHIFT  = 8;
   localparam int TERM_MAG_W  = 48;
   localparam int TOTAL_W     = 51;
   localparam int MAXQ_W      = LIM_W + FRAC_BITS;

   localparam logic signed [STATE_W-1:0] ERR_HI = {1'b0, {(STATE_W-1){1'b1}}};
   localparam logic signed [STATE_W-1:0] ERR_LO = {1'b1, {(STATE_W-1){1'b0}}};

endpackage

`default_nettype wire

FILE: rtl/grp_if.sv
// Valid/ready channel interfaces for the gyro rotation PID block:
// request channel and response channel. Depends on grp_pkg.
`default_nettype none

interface grp_req_if
   import grp_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic [REQ_TYPE_W-1:0]      req_type;
   logic signed [START_W-1:0]  start_error;
   logic signed [GYRO_W-1:0]   gyro_raw;
   logic [US_W-1:0]            elapsed_us;

   modport source (output valid, output req_type, output start_error,
                   output gyro_raw, output elapsed_us, input ready);
   modport sink   (input valid, input req_type, input start_error,
                   input gyro_raw, input elapsed_us, output ready);
endinterface

interface grp_rsp_if
   import grp_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic signed [DRIVE_W-1:0]  motor_drive;
   logic                       done_res;

   modport source (output valid, output motor_drive, output done_res, input ready);
   modport sink   (input valid, input motor_drive, input done_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/gyro_rotate_pid.sv
// Heading-rotation PID controller with clamped drive output.
// Depends on grp_pkg and the channel interfaces in grp_if.sv.
// Usage:
//  - req_bus carries one transaction per start or gyro sample. A start loads
//    the angle to turn and clears the integral and prior error; a sample
//    updates the error, integral and derivative and computes a drive.
//  - rsp_bus returns exactly one transaction per request: motor_drive and
//    done_res. It is held in an output register, so the next request is
//    taken while a result still waits for rsp_bus.ready.
//  - A start goes straight to S_EMIT and a sample runs the multiply, divide,
//    post, clamp and drive steps before it reaches the output register;
//    req_bus.ready is low meanwhile, so no new request is taken until then.
//  - The time is set by one shared divider that develops 4 quotient bits a
//    cycle (three divisions, each after a load step) and one shared 25x20
//    multiplier that forms each product in two halves (six products).
//  - If rsp_bus.ready stays low, the next finished result waits in the
//    sequencer until the output register frees up; nothing is dropped.
//  - Synchronous reset restores the register defaults, clears the
//    controller state and empties the output register.
//  - csr_write writes one register per cycle; write only while the block is idle (not enforced by the block).
`default_nettype none

module gyro_rotate_pid
   import grp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   grp_req_if.sink               req_bus,
   grp_rsp_if.source             rsp_bus,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_SETUP, S_MUL_LO, S_MUL_HI, S_DIV_INIT, S_DIV,
      S_POST, S_CLAMP, S_DRIVE, S_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_DELTA, OP_SUM, OP_DERIV, OP_TERM_P, OP_TERM_I, OP_TERM_D
   } op_type;

   // configuration registers
   logic [GAIN_W-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [TOL_W-1:0]  error_tol_ff, rate_tol_ff;
   logic [LIM_W-1:0]  min_drive_ff, max_drive_ff;

   // sequencer and datapath registers
   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   logic [US_W-1:0]            us_ff, us_in;
   logic [RATE_W-1:0]          rate_mag_ff, rate_mag_in;
   logic signed [STATE_W-1:0]  angle_error_ff, angle_error_in;
   logic signed [STATE_W-1:0]  error_sum_ff, error_sum_in;
   logic signed [STATE_W-1:0]  last_error_ff, last_error_in;
   logic [TERM_W-1:0]          deriv_mag_ff, deriv_mag_in;
   logic                       deriv_neg_ff, deriv_neg_in;
   logic [MUL_A_W-1:0]         mul_a_ff, mul_a_in;
   logic [MUL_B_W-1:0]         mul_b_ff, mul_b_in;
   logic                       op_neg_ff, op_neg_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [DIV_R_W-1:0]         div_den_ff, div_den_in;
   logic [DIV_R_W-1:0]         div_rem_ff, div_rem_in;
   logic [DIV_Q_W-1:0]         div_quo_ff, div_quo_in;
   logic [DIV_CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic                       div_ovf_ff, div_ovf_in;
   logic signed [TOTAL_W-1:0]  total_ff, total_in;
   logic [MAXQ_W-1:0]          mag_ff, mag_in;
   logic                       mag_neg_ff, mag_neg_in;
   logic signed [DRIVE_W-1:0]  res_drive_ff, res_drive_in;
   logic                       res_done_ff, res_done_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_W-1:0]  rsp_drive_ff, rsp_drive_in;
   logic                       rsp_done_ff, rsp_done_in;

   // shared multiplier: one half of operand A per cycle
   logic [MUL_HALF_W-1:0] mul_x;
   logic [MUL_P_W-1:0]    mul_p;

   assign mul_x = (state_ff == S_MUL_HI) ? MUL_HALF_W'(mul_a_ff[MUL_A_W-1:MUL_HALF_W])
                                         : mul_a_ff[MUL_HALF_W-1:0];
   assign mul_p = MUL_P_W'(mul_x) * MUL_P_W'(mul_b_ff);

   // shared divider: four restoring steps per cycle on the narrow remainder
   logic [DIV_R_W-1:0]  div_rem_step;
   logic [DIV_STEP-1:0] div_bits;

   always_comb begin
      logic [DIV_R_W:0] trial;
      div_rem_step = div_rem_ff;
      div_bits     = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial = {div_rem_step, div_quo_ff[DIV_Q_W-1-i]};
         if (trial >= {1'b0, div_den_ff}) begin
            div_rem_step            = DIV_R_W'(trial - {1'b0, div_den_ff});
            div_bits[DIV_STEP-1-i]  = 1'b1;
         end else begin
            div_rem_step = trial[DIV_R_W-1:0];
         end
      end
   end

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.motor_drive = rsp_drive_ff;
   assign rsp_bus.done_res    = rsp_done_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PROP_GAIN_RST;
         integ_gain_ff <= INTEG_GAIN_RST;
         deriv_gain_ff <= DERIV_GAIN_RST;
         error_tol_ff  <= ERROR_TOL_RST;
         rate_tol_ff   <= RATE_TOL_RST;
         min_drive_ff  <= MIN_DRIVE_RST;
         max_drive_ff  <= MAX_DRIVE_RST;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_data[GAIN_W-1:0];
            CSR_INTEG_GAIN: integ_gain_ff <= csr_data[GAIN_W-1:0];
            CSR_DERIV_GAIN: deriv_gain_ff <= csr_data[GAIN_W-1:0];
            CSR_ERROR_TOL:  error_tol_ff  <= csr_data[TOL_W-1:0];
            CSR_RATE_TOL:   rate_tol_ff   <= csr_data[TOL_W-1:0];
            CSR_MIN_DRIVE:  min_drive_ff  <= csr_data[LIM_W-1:0];
            CSR_MAX_DRIVE:  max_drive_ff  <= csr_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer next-state and datapath
   always_comb begin
      logic signed [RAW_MAG_W-1:0] raw_ext;
      logic [RAW_MAG_W-1:0]        raw_mag;
      logic [RAW_PROD_W-1:0]       raw_prod;
      logic [RATE_SCALE_W-1:0]     rate_scaled;
      logic [START_W-1:0]          start_mag;
      logic [STATE_W-1:0]          ae_mag, sum_mag;
      logic signed [STATE_W:0]     diff;
      logic [STATE_W:0]            diff_mag;
      logic [TERM_W-1:0]           ae_cl, sum_cl, deriv_cl;
      logic signed [STATE_W:0]     delta_s, ae_next;
      logic signed [STATE_W+1:0]   inc_s, sum_next;
      logic [TERM_MAG_W-1:0]       term_mag;
      logic signed [TOTAL_W-1:0]   term_s;
      logic [TOTAL_W-1:0]          total_mag;
      logic [MAXQ_W-1:0]           maxq, minq, raised;
      logic [LIM_W-1:0]            drive_mag;
      logic                        done;

      state_in       = state_ff;
      op_in          = op_ff;
      us_in          = us_ff;
      rate_mag_in    = rate_mag_ff;
      angle_error_in = angle_error_ff;
      error_sum_in   = error_sum_ff;
      last_error_in  = last_error_ff;
      deriv_mag_in   = deriv_mag_ff;
      deriv_neg_in   = deriv_neg_ff;
      mul_a_in       = mul_a_ff;
      mul_b_in       = mul_b_ff;
      op_neg_in      = op_neg_ff;
      prod_in        = prod_ff;
      div_den_in     = div_den_ff;
      div_rem_in     = div_rem_ff;
      div_quo_in     = div_quo_ff;
      div_cnt_in     = div_cnt_ff;
      div_ovf_in     = div_ovf_ff;
      total_in       = total_ff;
      mag_in         = mag_ff;
      mag_neg_in     = mag_neg_ff;
      res_drive_in   = res_drive_ff;
      res_done_in    = res_done_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_drive_in   = rsp_drive_ff;
      rsp_done_in    = rsp_done_ff;

      // gyro reading to rate magnitude, saturated
      raw_ext     = {req_bus.gyro_raw[GYRO_W-1], req_bus.gyro_raw};
      raw_mag     = raw_ext[RAW_MAG_W-1] ? RAW_MAG_W'(-raw_ext) : RAW_MAG_W'(raw_ext);
      raw_prod    = RAW_PROD_W'(raw_mag) * GYRO_FULL_SCALE;
      rate_scaled = (RATE_SCALE_W'(raw_prod) << FRAC_BITS) >> GYRO_SHIFT;

      start_mag = req_bus.start_error[START_W-1] ? START_W'(-req_bus.start_error)
                                                 : START_W'(req_bus.start_error);

      // magnitudes of the controller state
      ae_mag   = angle_error_ff[STATE_W-1] ? STATE_W'(-angle_error_ff)
                                           : STATE_W'(angle_error_ff);
      sum_mag  = error_sum_ff[STATE_W-1] ? STATE_W'(-error_sum_ff)
                                         : STATE_W'(error_sum_ff);
      diff     = {angle_error_ff[STATE_W-1], angle_error_ff}
               - {last_error_ff[STATE_W-1], last_error_ff};
      diff_mag = diff[STATE_W] ? (STATE_W+1)'(-diff) : (STATE_W+1)'(diff);
      ae_cl    = (ae_mag > STATE_W'(TERM_LIM)) ? TERM_LIM : ae_mag[TERM_W-1:0];
      sum_cl   = (sum_mag > STATE_W'(TERM_LIM)) ? TERM_LIM : sum_mag[TERM_W-1:0];
      deriv_cl = (div_ovf_ff || div_quo_ff > DIV_Q_W'(TERM_LIM)) ? TERM_LIM
                                                                : div_quo_ff[TERM_W-1:0];

      // error update: subtract the signed angle turned
      delta_s = op_neg_ff ? -$signed({18'b0, div_quo_ff[RATE_W-1:0]})
                          :  $signed({18'b0, div_quo_ff[RATE_W-1:0]});
      ae_next = $signed({angle_error_ff[STATE_W-1], angle_error_ff}) - delta_s;

      // integral update: add the signed error-time product
      inc_s    = op_neg_ff ? -$signed({2'b0, div_quo_ff}) : $signed({2'b0, div_quo_ff});
      sum_next = $signed({{2{error_sum_ff[STATE_W-1]}}, error_sum_ff}) + inc_s;

      // PID term from the gain product
      term_mag = prod_ff[GAIN_SHIFT +: TERM_MAG_W];
      term_s   = op_neg_ff ? -$signed(TOTAL_W'(term_mag)) : $signed(TOTAL_W'(term_mag));

      total_mag = total_ff[TOTAL_W-1] ? TOTAL_W'(-total_ff) : TOTAL_W'(total_ff);
      maxq      = {max_drive_ff, {FRAC_BITS{1'b0}}};
      minq      = {min_drive_ff, {FRAC_BITS{1'b0}}};
      raised    = (mag_ff != '0 && mag_ff < minq) ? minq : mag_ff;
      drive_mag = raised[MAXQ_W-1:FRAC_BITS];
      done      = (ae_mag <= STATE_W'(error_tol_ff)) && (rate_mag_ff <= RATE_W'(rate_tol_ff));

      // drop the output once the receiver takes it
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.req_type == REQ_START) begin
                  angle_error_in = STATE_W'(req_bus.start_error);
                  error_sum_in   = '0;
                  last_error_in  = '0;
                  res_drive_in   = '0;
                  res_done_in    = (start_mag <= START_W'(error_tol_ff));
                  state_in       = S_EMIT;
               end else begin
                  us_in       = (req_bus.elapsed_us == '0) ? US_W'(1) : req_bus.elapsed_us;
                  rate_mag_in = (rate_scaled > RATE_SCALE_W'(RATE_MAX)) ? RATE_MAX
                                                                     : rate_scaled[RATE_W-1:0];
                  op_neg_in   = req_bus.gyro_raw[GYRO_W-1];
                  op_in       = OP_DELTA;
                  state_in    = S_SETUP;
               end
            end
         end

         // select operands for the next product
         S_SETUP: begin
            case (op_ff)
               OP_DELTA: begin
                  mul_a_in   = MUL_A_W'(rate_mag_ff);
                  mul_b_in   = us_ff;
                  div_den_in = US_PER_S;
               end
               OP_SUM: begin
                  mul_a_in   = MUL_A_W'(ae_mag);
                  mul_b_in   = us_ff;
                  op_neg_in  = angle_error_ff[STATE_W-1];
                  div_den_in = US_PER_S;
               end
               OP_DERIV: begin
                  mul_a_in   = diff_mag;
                  mul_b_in   = US_PER_S;
                  op_neg_in  = diff[STATE_W];
                  div_den_in = us_ff;
               end
               OP_TERM_P: begin
                  mul_a_in  = MUL_A_W'(ae_cl);
                  mul_b_in  = MUL_B_W'(prop_gain_ff);
                  op_neg_in = angle_error_ff[STATE_W-1];
               end
               OP_TERM_I: begin
                  mul_a_in  = MUL_A_W'(sum_cl);
                  mul_b_in  = MUL_B_W'(integ_gain_ff);
                  op_neg_in = error_sum_ff[STATE_W-1];
               end
               default: begin
                  mul_a_in  = MUL_A_W'(deriv_mag_ff);
                  mul_b_in  = MUL_B_W'(deriv_gain_ff);
                  op_neg_in = deriv_neg_ff;
               end
            endcase
            state_in = S_MUL_LO;
         end

         S_MUL_LO: begin
            prod_in  = PROD_W'(mul_p);
            state_in = S_MUL_HI;
         end

         S_MUL_HI: begin
            prod_in = prod_ff + (PROD_W'(mul_p) << MUL_HALF_W);
            if (op_ff == OP_DELTA || op_ff == OP_SUM || op_ff == OP_DERIV) begin
               state_in = S_DIV_INIT;
            end else begin
               state_in = S_POST;
            end
         end

         // align the dividend so the quotient fits the chosen width
         S_DIV_INIT: begin
            case (op_ff)
               OP_DELTA: begin
                  div_rem_in = prod_ff[DIV_K_DELTA +: DIV_R_W];
                  div_quo_in = {prod_ff[DIV_K_DELTA-1:0], {(DIV_Q_W-DIV_K_DELTA){1'b0}}};
                  div_cnt_in = DIV_CNT_W'(DIV_K_DELTA / DIV_STEP - 1);
                  div_ovf_in = 1'b0;
               end
               OP_SUM: begin
                  div_rem_in = prod_ff[DIV_K_SUM +: DIV_R_W];
                  div_quo_in = prod_ff[DIV_Q_W-1:0];
                  div_cnt_in = DIV_CNT_W'(DIV_K_SUM / DIV_STEP - 1);
                  div_ovf_in = 1'b0;
               end
               default: begin
                  div_rem_in = prod_ff[DIV_K_DERIV +: DIV_R_W];
                  div_quo_in = {prod_ff[DIV_K_DERIV-1:0], {(DIV_Q_W-DIV_K_DERIV){1'b0}}};
                  div_cnt_in = DIV_CNT_W'(DIV_K_DERIV / DIV_STEP - 1);
                  div_ovf_in = (prod_ff[PROD_W-1:DIV_K_DERIV] >= DIV_TOP_W'(div_den_ff));
               end
            endcase
            state_in = S_DIV;
         end

         S_DIV: begin
            div_rem_in = div_rem_step;
            div_quo_in = {div_quo_ff[DIV_Q_W-DIV_STEP-1:0], div_bits};
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               state_in = S_POST;
            end
         end

         // apply the finished product or quotient and advance to the next step
         S_POST: begin
            state_in = S_SETUP;
            case (op_ff)
               OP_DELTA: begin
                  if (ae_next[STATE_W] != ae_next[STATE_W-1]) begin
                     angle_error_in = ae_next[STATE_W] ? ERR_LO : ERR_HI;
                  end else begin
                     angle_error_in = ae_next[STATE_W-1:0];
                  end
                  op_in = OP_SUM;
               end
               OP_SUM: begin
                  if (sum_next[STATE_W+1:STATE_W-1] != '0 &&
                      sum_next[STATE_W+1:STATE_W-1] != '1) begin
                     error_sum_in = sum_next[STATE_W+1] ? ERR_LO : ERR_HI;
                  end else begin
                     error_sum_in = sum_next[STATE_W-1:0];
                  end
                  op_in = OP_DERIV;
               end
               OP_DERIV: begin
                  deriv_mag_in  = deriv_cl;
                  deriv_neg_in  = op_neg_ff;
                  last_error_in = angle_error_ff;
                  op_in         = OP_TERM_P;
               end
               OP_TERM_P: begin
                  total_in = term_s;
                  op_in    = OP_TERM_I;
               end
               OP_TERM_I: begin
                  total_in = total_ff + term_s;
                  op_in    = OP_TERM_D;
               end
               default: begin
                  total_in = total_ff + term_s;
                  state_in = S_CLAMP;
               end
            endcase
         end

         // clamp the total magnitude to the drive limit
         S_CLAMP: begin
            mag_neg_in = total_ff[TOTAL_W-1];
            mag_in     = (total_mag > TOTAL_W'(maxq)) ? maxq : total_mag[MAXQ_W-1:0];
            state_in   = S_DRIVE;
         end

         // raise small drives, scale down, apply the completion deadband
         S_DRIVE: begin
            res_done_in = done;
            if (done) begin
               res_drive_in = '0;
            end else if (mag_neg_ff) begin
               res_drive_in = -$signed(DRIVE_W'(drive_mag));
            end else begin
               res_drive_in = $signed(DRIVE_W'(drive_mag));
            end
            state_in = S_EMIT;
         end

         // hold the result until the output register is free
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = res_drive_ff;
               rsp_done_in  = res_done_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         op_ff          <= OP_DELTA;
         rsp_valid_ff   <= 1'b0;
         angle_error_ff <= '0;
         error_sum_ff   <= '0;
         last_error_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         op_ff          <= op_in;
         rsp_valid_ff   <= rsp_valid_in;
         angle_error_ff <= angle_error_in;
         error_sum_ff   <= error_sum_in;
         last_error_ff  <= last_error_in;
      end
      us_ff        <= us_in;
      rate_mag_ff  <= rate_mag_in;
      deriv_mag_ff <= deriv_mag_in;
      deriv_neg_ff <= deriv_neg_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      op_neg_ff    <= op_neg_in;
      prod_ff      <= prod_in;
      div_den_ff   <= div_den_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_cnt_ff   <= div_cnt_in;
      div_ovf_ff   <= div_ovf_in;
      total_ff     <= total_in;
      mag_ff       <= mag_in;
      mag_neg_ff   <= mag_neg_in;
      res_drive_ff <= res_drive_in;
      res_done_ff  <= res_done_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_done_ff  <= rsp_done_in;
   end

endmodule

`default_nettype wire
